// File: rtl/ats_pkg.sv
// Shared request and result types for the alias table sampler.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] entry_value;
        logic [15:0]        entry_weight;
        logic               last_entry;
        logic [7:0]         sample_index;
        logic [15:0]        sample_fraction;
    } ats_req_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               used_alias;
        logic               not_ready;
        logic               load_overflow;
    } ats_rsp_t;

endpackage
`default_nettype wire

// File: rtl/ats_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/alias_table_sampler.sv
// Top level: Vose alias table loader, builder and sampler.
//
//  channel | ports                      | moves
//  --------+----------------------------+---------------------------------
//  in      | s_valid, s_ready, s_data   | load or sample request
//  out     | m_valid, m_ready, m_data   | one result per sample request
//
// A load is written in the idle state. A load marked last then runs the build:
// scan read and write per entry, pairing pop, small read, large read and write
// per step, leftover pop and write per entry, and a final pop of each loop.
// A sample reads the residual and value, checks them, reads the alias value
// when the alias is taken, then hands off; a sample with no built table goes
// straight to hand-off. The residual/value memory read ports set these steps.
// Reset is synchronous, active low; memories are not cleared.
// A result waiting on m_ready holds the next request only at hand-off time.
`timescale 1ns / 1ps
`default_nettype none
module alias_table_sampler #(
    parameter int MAX_ENTRIES   = 256,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ats_pkg::ats_req_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ats_pkg::ats_rsp_t     m_data
);
    import ats_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W = WEIGHT_BITS + CNT_W;
    localparam int WIN_W = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int FIN_W = (FRACTION_BITS < 16) ? FRACTION_BITS : 16;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int KEEP_W = RES_W + FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_WR, ST_PAIR_POP, ST_PAIR_RS, ST_PAIR_RG,
        ST_PAIR_WR, ST_LEFT_POP, ST_LEFT_WR, ST_SAMP_CHK, ST_SAMP_ALIAS, ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [RES_W-1:0]     total_reg, total_next;
    logic                 ready_reg, ready_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     ns_reg, ns_next;
    logic [CNT_W-1:0]     nl_reg, nl_next;
    logic [IDX_W-1:0]     s_idx_reg, s_idx_next;
    logic [IDX_W-1:0]     g_idx_reg, g_idx_next;
    logic [RES_W-1:0]     rs_reg, rs_next;
    logic                 from_small_reg, from_small_next;
    logic [FIN_W+RES_W-1:0] prod_reg, prod_next;
    ats_rsp_t             pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    ats_rsp_t             m_data_reg, m_data_next;

    // memory ports
    logic               val_we, res_we, ali_we, sml_we, lrg_we;
    logic [IDX_W-1:0]   val_wa, res_wa, ali_wa, sml_wa, lrg_wa;
    logic [IDX_W-1:0]   val_ra, res_ra, ali_ra, sml_ra, lrg_ra;
    logic [31:0]        val_wd, val_rd;
    logic [RES_W-1:0]   res_wd, res_rd;
    logic [IDX_W-1:0]   ali_wd, ali_rd, sml_wd, sml_rd, lrg_wd, lrg_rd;

    ats_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_value (
        .aclk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));
    ats_ram #(.WIDTH(RES_W), .DEPTH(MAX_ENTRIES)) u_resid (
        .aclk, .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd));
    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_alias (
        .aclk, .we(ali_we), .waddr(ali_wa), .wdata(ali_wd), .raddr(ali_ra), .rdata(ali_rd));
    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small (
        .aclk, .we(sml_we), .waddr(sml_wa), .wdata(sml_wd), .raddr(sml_ra), .rdata(sml_rd));
    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large (
        .aclk, .we(lrg_we), .waddr(lrg_wa), .wdata(lrg_wd), .raddr(lrg_ra), .rdata(lrg_rd));

    logic [CNT_W-1:0]       cnt_eff, ns_dec, nl_dec;
    logic [RES_W-1:0]       tot_eff, w_ext;
    logic [CMP_W-1:0]       idx_ext, cnt_ext, idx_cl;
    logic [RES_W+CNT_W-1:0] scaled;
    logic [RES_W:0]         merged;
    logic [KEEP_W-1:0]      lhs, rhs;
    logic [IDX_W-1:0]       left_idx;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        cnt_eff  = ready_reg ? '0 : count_reg;
        tot_eff  = ready_reg ? '0 : total_reg;
        w_ext    = RES_W'(s_data.entry_weight[WIN_W-1:0]);
        idx_ext  = CMP_W'(s_data.sample_index);
        cnt_ext  = CMP_W'(count_reg);
        idx_cl   = (idx_ext >= cnt_ext) ? cnt_ext - 1'b1 : idx_ext;
        ns_dec   = ns_reg - 1'b1;
        nl_dec   = nl_reg - 1'b1;
        scaled   = res_rd * count_reg;
        merged   = {1'b0, res_rd} + {1'b0, rs_reg} - {1'b0, total_reg};
        lhs      = KEEP_W'(prod_reg);
        rhs      = KEEP_W'(res_rd) << FRACTION_BITS;
        left_idx = from_small_reg ? sml_rd : lrg_rd;

        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        ready_next      = ready_reg;
        ovf_next        = ovf_reg;
        k_next          = k_reg;
        ns_next         = ns_reg;
        nl_next         = nl_reg;
        s_idx_next      = s_idx_reg;
        g_idx_next      = g_idx_reg;
        rs_next         = rs_reg;
        from_small_next = from_small_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        val_we = 1'b0; val_wa = cnt_eff[IDX_W-1:0]; val_wd = s_data.entry_value;
        val_ra = idx_cl[IDX_W-1:0];
        res_we = 1'b0; res_wa = cnt_eff[IDX_W-1:0]; res_wd = w_ext;
        res_ra = idx_cl[IDX_W-1:0];
        ali_we = 1'b0; ali_wa = s_idx_reg; ali_wd = g_idx_reg;
        ali_ra = idx_cl[IDX_W-1:0];
        sml_we = 1'b0; sml_wa = ns_reg[IDX_W-1:0]; sml_wd = k_reg[IDX_W-1:0];
        sml_ra = ns_dec[IDX_W-1:0];
        lrg_we = 1'b0; lrg_wa = nl_reg[IDX_W-1:0]; lrg_wd = k_reg[IDX_W-1:0];
        lrg_ra = nl_dec[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.kind == KIND_LOAD) begin
                        ready_next = 1'b0;
                        count_next = cnt_eff;
                        total_next = tot_eff;
                        if (cnt_eff < CNT_W'(MAX_ENTRIES)) begin
                            val_we     = 1'b1;
                            res_we     = 1'b1;
                            total_next = tot_eff + w_ext;
                            count_next = cnt_eff + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (s_data.last_entry && count_next != '0) begin
                            k_next     = '0;
                            ns_next    = '0;
                            nl_next    = '0;
                            state_next = ST_SCAN_RD;
                        end
                    end else if (!ready_reg || count_reg == '0) begin
                        pend_next.sample_value  = '0;
                        pend_next.used_alias    = 1'b0;
                        pend_next.not_ready     = 1'b1;
                        pend_next.load_overflow = ovf_reg;
                        state_next              = ST_EMIT;
                    end else begin
                        prod_next  = s_data.sample_fraction[FIN_W-1:0] * total_reg;
                        state_next = ST_SAMP_CHK;
                    end
                end
            end
            ST_SCAN_RD: begin
                res_ra     = k_reg[IDX_W-1:0];
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR: begin
                res_we = 1'b1;
                res_wa = k_reg[IDX_W-1:0];
                res_wd = scaled[RES_W-1:0];
                if (scaled[RES_W-1:0] > total_reg) begin
                    lrg_we  = 1'b1;
                    nl_next = nl_reg + 1'b1;
                end else begin
                    sml_we  = 1'b1;
                    ns_next = ns_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = (k_next == count_reg) ? ST_PAIR_POP : ST_SCAN_RD;
            end
            ST_PAIR_POP: begin
                if (ns_reg != '0 && nl_reg != '0) begin
                    ns_next    = ns_dec;
                    nl_next    = nl_dec;
                    state_next = ST_PAIR_RS;
                end else begin
                    state_next = ST_LEFT_POP;
                end
            end
            ST_PAIR_RS: begin
                s_idx_next = sml_rd;
                g_idx_next = lrg_rd;
                res_ra     = sml_rd;
                state_next = ST_PAIR_RG;
            end
            ST_PAIR_RG: begin
                rs_next    = res_rd;
                res_ra     = g_idx_reg;
                state_next = ST_PAIR_WR;
            end
            ST_PAIR_WR: begin
                ali_we = 1'b1;
                res_we = 1'b1;
                res_wa = g_idx_reg;
                res_wd = merged[RES_W-1:0];
                sml_wd = g_idx_reg;
                lrg_wd = g_idx_reg;
                if (merged[RES_W-1:0] > total_reg) begin
                    lrg_we  = 1'b1;
                    nl_next = nl_reg + 1'b1;
                end else begin
                    sml_we  = 1'b1;
                    ns_next = ns_reg + 1'b1;
                end
                state_next = ST_PAIR_POP;
            end
            ST_LEFT_POP: begin
                if (ns_reg != '0) begin
                    ns_next         = ns_dec;
                    from_small_next = 1'b1;
                    state_next      = ST_LEFT_WR;
                end else if (nl_reg != '0) begin
                    nl_next         = nl_dec;
                    from_small_next = 1'b0;
                    state_next      = ST_LEFT_WR;
                end else begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LEFT_WR: begin
                res_we     = 1'b1;
                res_wa     = left_idx;
                res_wd     = total_reg;
                ali_we     = 1'b1;
                ali_wa     = left_idx;
                ali_wd     = left_idx;
                state_next = ST_LEFT_POP;
            end
            ST_SAMP_CHK: begin
                pend_next.not_ready     = 1'b0;
                pend_next.load_overflow = ovf_reg;
                if (lhs <= rhs) begin
                    pend_next.sample_value = val_rd;
                    pend_next.used_alias   = 1'b0;
                    state_next             = ST_EMIT;
                end else begin
                    val_ra     = ali_rd;
                    state_next = ST_SAMP_ALIAS;
                end
            end
            ST_SAMP_ALIAS: begin
                pend_next.sample_value = val_rd;
                pend_next.used_alias   = 1'b1;
                state_next             = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            ready_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            ready_reg   <= ready_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg          <= k_next;
        ns_reg         <= ns_next;
        nl_reg         <= nl_next;
        s_idx_reg      <= s_idx_next;
        g_idx_reg      <= g_idx_next;
        rs_reg         <= rs_next;
        from_small_reg <= from_small_next;
        prod_reg       <= prod_next;
        pend_reg       <= pend_next;
        m_data_reg     <= m_data_next;
    end

endmodule
`default_nettype wire
